// File: rtl/hmth_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hmth_pkg: shared types and constants
// Register indexes, reset values, fixed-point constants and the command and
// status groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package hmth_pkg;

    localparam int GRID_SIZE_DEF = 256;

    // configuration register indexes
    localparam logic [1:0] REG_HEIGHT_SCALE = 2'd0;
    localparam logic [1:0] REG_CELL_SPACING = 2'd1;
    localparam logic [1:0] REG_ORIGIN_X     = 2'd2;
    localparam logic [1:0] REG_ORIGIN_Z     = 2'd3;

    localparam logic [15:0] HEIGHT_SCALE_RST = 16'd17920;
    localparam logic [15:0] CELL_SPACING_RST = 16'd768;
    localparam logic [23:0] ORIGIN_RST       = 24'd0;

    // item kinds carried in the input tuser bit
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [16:0] FRAC_ONE = 17'h10000;
    // half of 255*65536, for round to nearest
    localparam logic [40:0] ROUND_C  = 41'd8355840;
    // ceil(2^32/255): floor(y/255) == (y*RECIP_M)>>32 for y < 2^24
    localparam logic [24:0] RECIP_M  = 25'd16843010;

    typedef struct packed {
        logic       load;      // capture the input item
        logic       mem_wr;    // write the captured sample
        logic       ax_sub;    // offset from origin
        logic       ax_mul;    // numerator, cell length, limit
        logic       ax_chk;    // range check, divider init
        logic       div_step;  // one quotient bit
        logic       rd_en;     // read a corner sample
        logic [1:0] rd_sel;    // which corner
        logic       acc_clr;
        logic       acc_en;
        logic       scale;
        logic       recip;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic is_write;
        logic off_grid;
    } status_t;

endpackage

`default_nettype wire

// File: rtl/heightmap_triangle_height_query.sv
`default_nettype none
// ----------------------------------------------------------------------------
// heightmap_triangle_height_query: terrain height lookup on a sample grid
// Holds a GRID_SIZE x GRID_SIZE grid of 8-bit samples and answers position
// queries with a triangle-interpolated, scaled Q8.8 height.
// ----------------------------------------------------------------------------
// Usage: a write item (tuser = 0) stores one sample and returns nothing; the
// next item can be accepted once the decode state has stored it. A query
// item (tuser = 1) returns exactly one transfer. Its result is loaded into
// the output register after the offset, multiply, range check, branch,
// divide, corner read, accumulate, scale and reciprocal states, and the next
// item can be accepted once the output state is left. A query's duration is
// set by the bit-serial divide by the cell length, which produces one
// quotient bit per cycle for both axes in parallel, followed by three reads
// of the single-port sample memory. Off-grid queries skip the divide and the
// corner reads. If the previous result is still waiting, a finished query
// holds until it is taken. One item is in flight at a time; a finished
// result sits in the output register so the next item can be accepted while
// it waits. Reading a sample never written since reset gives an undefined
// height. Configuration must be written only while the block is idle; the
// block itself does not enforce this.
// ----------------------------------------------------------------------------
module heightmap_triangle_height_query import hmth_pkg::*; #(
    parameter int GRID_SIZE = GRID_SIZE_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration writes
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_addr,
    input  wire logic [23:0] cfg_wdata,
    // input items
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // sample_row[7:0], sample_col[15:8], sample_value[23:16],
    // query_x[47:24], query_z[71:48]
    input  wire logic [71:0] s_tdata,
    // op[0]
    input  wire logic        s_tuser,
    // results
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // height[15:0]
    output logic [15:0]      m_tdata,
    // on_grid[0]
    output logic             m_tuser
);

    cmd_t    cmd;
    status_t sts;

    hmth_ctrl #(.GRID_SIZE(GRID_SIZE)) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // datapath captures the item on cmd.load, which the sequencer only
    // raises in the cycle of an input transfer
    hmth_dp #(.GRID_SIZE(GRID_SIZE)) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .in_data     (s_tdata),
        .in_op       (s_tuser),
        .cmd         (cmd),
        .sts         (sts),
        .out_height  (m_tdata),
        .out_on_grid (m_tuser)
    );

endmodule

`default_nettype wire

// File: rtl/hmth_axis.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hmth_axis: one axis of the grid lookup
// Offset from origin, range check against the grid, then a bit-serial
// restoring divide giving the cell index and a Q0.16 fraction.
// ----------------------------------------------------------------------------
module hmth_axis import hmth_pkg::*; #(
    parameter int GRID_SIZE = GRID_SIZE_DEF,
    localparam int IW = $clog2(GRID_SIZE)
) (
    input  wire logic          aclk,
    input  wire logic          sub_en,
    input  wire logic          mul_en,
    input  wire logic          chk_en,
    input  wire logic          step_en,
    input  wire logic [23:0]   pos,
    input  wire logic [23:0]   org,
    input  wire logic [15:0]   spacing,
    output logic               off,
    output logic [IW-1:0]      cell_idx,
    output logic [15:0]        frac
);

    localparam int GW = $clog2(GRID_SIZE + 1);
    localparam int NW = 24 + IW;
    localparam int DW = 16 + GW;
    localparam int LW = DW + IW;
    localparam int RW = DW + 1;
    localparam int QW = IW + 16;
    localparam int CW = (NW > LW) ? NW : LW;

    logic [24:0]   d_reg;
    logic [NW-1:0] num_reg;
    logic [DW-1:0] den_reg;
    logic [LW-1:0] lim_reg;
    logic          off_reg;
    logic [RW-1:0] rem_reg;
    logic [QW-1:0] quo_reg;
    logic [RW-1:0] trial;

    assign trial = {rem_reg[RW-2:0], quo_reg[QW-1]};

    always_ff @(posedge aclk) begin
        if (sub_en) begin
            d_reg <= {pos[23], pos} - {org[23], org};
        end
        if (mul_en) begin
            num_reg <= NW'(d_reg[23:0]) * NW'(GRID_SIZE - 1);
            den_reg <= DW'(spacing) * DW'(GRID_SIZE);
            // zero spacing gives a zero limit, so every query is off grid
            lim_reg <= LW'(spacing) * LW'(GRID_SIZE * (GRID_SIZE - 1));
        end
        if (chk_en) begin
            off_reg <= d_reg[24] | (CW'(num_reg) >= CW'(lim_reg));
            rem_reg <= RW'(num_reg >> IW);
            quo_reg <= {num_reg[IW-1:0], 16'd0};
        end else if (step_en) begin
            if (trial >= RW'(den_reg)) begin
                rem_reg <= trial - RW'(den_reg);
                quo_reg <= {quo_reg[QW-2:0], 1'b1};
            end else begin
                rem_reg <= trial;
                quo_reg <= {quo_reg[QW-2:0], 1'b0};
            end
        end
    end

    assign off      = off_reg;
    assign cell_idx = quo_reg[QW-1:16];
    assign frac     = quo_reg[15:0];

endmodule

`default_nettype wire

// File: rtl/hmth_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hmth_dp: datapath
// Config registers, sample memory, two axis units, corner blend and scaling.
// ----------------------------------------------------------------------------
module hmth_dp import hmth_pkg::*; #(
    parameter int GRID_SIZE = GRID_SIZE_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_addr,
    input  wire logic [23:0] cfg_wdata,
    input  wire logic [71:0] in_data,
    input  wire logic        in_op,
    input  wire cmd_t        cmd,
    output status_t          sts,
    output logic [15:0]      out_height,
    output logic             out_on_grid
);

    localparam int IW    = $clog2(GRID_SIZE);
    localparam int AW    = 2 * IW;
    localparam int DEPTH = 1 << AW;

    logic [15:0] height_scale_reg;
    logic [15:0] cell_spacing_reg;
    logic [23:0] origin_x_reg;
    logic [23:0] origin_z_reg;

    logic        op_reg;
    logic [7:0]  row_reg, col_reg, val_reg;
    logic [23:0] qx_reg, qz_reg;

    logic [7:0]  mem [DEPTH];
    logic [7:0]  rdata_reg;
    logic [16:0] w_reg;
    logic [23:0] acc_reg;
    logic [40:0] t_reg;
    logic [16:0] q_reg;
    logic [15:0] height_reg;
    logic        on_grid_reg;

    logic          off_x, off_z;
    logic [IW-1:0] gx, gz, gx1, gz1;
    logic [15:0]   fx, fz;
    logic [17:0]   fsum;
    logic          upper;
    logic [16:0]   w_sel;
    logic [AW-1:0] rd_addr;
    logic [24:0]   prod;
    logic [48:0]   rprod;
    logic          wr_ok;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            height_scale_reg <= HEIGHT_SCALE_RST;
            cell_spacing_reg <= CELL_SPACING_RST;
            origin_x_reg     <= ORIGIN_RST;
            origin_z_reg     <= ORIGIN_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_HEIGHT_SCALE: height_scale_reg <= cfg_wdata[15:0];
                REG_CELL_SPACING: cell_spacing_reg <= cfg_wdata[15:0];
                REG_ORIGIN_X:     origin_x_reg     <= cfg_wdata;
                REG_ORIGIN_Z:     origin_z_reg     <= cfg_wdata;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg  <= in_op;
            row_reg <= in_data[7:0];
            col_reg <= in_data[15:8];
            val_reg <= in_data[23:16];
            qx_reg  <= in_data[47:24];
            qz_reg  <= in_data[71:48];
        end
    end

    hmth_axis #(.GRID_SIZE(GRID_SIZE)) u_axis_x (
        .aclk(aclk), .sub_en(cmd.ax_sub), .mul_en(cmd.ax_mul), .chk_en(cmd.ax_chk),
        .step_en(cmd.div_step), .pos(qx_reg), .org(origin_x_reg),
        .spacing(cell_spacing_reg), .off(off_x), .cell_idx(gx), .frac(fx)
    );

    hmth_axis #(.GRID_SIZE(GRID_SIZE)) u_axis_z (
        .aclk(aclk), .sub_en(cmd.ax_sub), .mul_en(cmd.ax_mul), .chk_en(cmd.ax_chk),
        .step_en(cmd.div_step), .pos(qz_reg), .org(origin_z_reg),
        .spacing(cell_spacing_reg), .off(off_z), .cell_idx(gz), .frac(fz)
    );

    assign sts = '{is_write: (op_reg == OP_WRITE), off_grid: (off_x | off_z)};

    // corner selection; fx+fz == 1.0 stays on the upper triangle
    assign gx1   = gx + IW'(1);
    assign gz1   = gz + IW'(1);
    assign fsum  = 18'(fx) + 18'(fz);
    assign upper = (fsum <= 18'(FRAC_ONE));

    always_comb begin
        case (cmd.rd_sel)
            2'd0: begin
                rd_addr = upper ? {gx, gz} : {gx1, gz};
                w_sel   = upper ? 17'(18'(FRAC_ONE) - fsum) : FRAC_ONE - 17'(fz);
            end
            2'd1: begin
                rd_addr = upper ? {gx1, gz} : {gx1, gz1};
                w_sel   = upper ? 17'(fx) : 17'(fsum - 18'(FRAC_ONE));
            end
            2'd2: begin
                rd_addr = {gx, gz1};
                w_sel   = upper ? 17'(fz) : FRAC_ONE - 17'(fx);
            end
            default: begin
                rd_addr = '0;
                w_sel   = '0;
            end
        endcase
    end

    assign wr_ok = (int'(row_reg) < GRID_SIZE) && (int'(col_reg) < GRID_SIZE);

    always_ff @(posedge aclk) begin
        if (cmd.mem_wr && wr_ok) begin
            mem[{IW'(row_reg), IW'(col_reg)}] <= val_reg;
        end
        if (cmd.rd_en) begin
            rdata_reg <= mem[rd_addr];
            w_reg     <= w_sel;
        end
    end

    assign prod  = 25'(w_reg) * 25'(rdata_reg);
    assign rprod = 49'(t_reg[39:16]) * 49'(RECIP_M);

    always_ff @(posedge aclk) begin
        if (cmd.acc_clr) begin
            acc_reg <= '0;
        end else if (cmd.acc_en) begin
            acc_reg <= acc_reg + prod[23:0];
        end
        if (cmd.scale) begin
            t_reg <= 41'(acc_reg) * 41'(height_scale_reg) + ROUND_C;
        end
        if (cmd.recip) begin
            q_reg <= rprod[48:32];
        end
        if (cmd.out_load) begin
            if (sts.off_grid) begin
                height_reg  <= '0;
                on_grid_reg <= 1'b0;
            end else begin
                height_reg  <= q_reg[16] ? 16'hFFFF : q_reg[15:0];
                on_grid_reg <= 1'b1;
            end
        end
    end

    assign out_height  = height_reg;
    assign out_on_grid = on_grid_reg;

endmodule

`default_nettype wire

// File: rtl/hmth_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hmth_ctrl: sequencer
// Steps an item through decode, a query on through axis lookup, divide,
// corner reads and scaling (off grid: no divide, no reads); owns both handshakes.
// ----------------------------------------------------------------------------
module hmth_ctrl import hmth_pkg::*; #(
    parameter int GRID_SIZE = GRID_SIZE_DEF
) (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_tvalid,
    output logic         s_tready,
    output logic         m_tvalid,
    input  wire logic    m_tready,
    input  wire status_t sts,
    output cmd_t         cmd
);

    localparam int DIVN = $clog2(GRID_SIZE) + 16;
    localparam int CNTW = $clog2(DIVN + 1);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_DEC   = 4'd1;
    localparam logic [3:0] ST_MUL   = 4'd2;
    localparam logic [3:0] ST_CHK   = 4'd3;
    localparam logic [3:0] ST_BR    = 4'd4;
    localparam logic [3:0] ST_DIV   = 4'd5;
    localparam logic [3:0] ST_RD0   = 4'd6;
    localparam logic [3:0] ST_RD1   = 4'd7;
    localparam logic [3:0] ST_RD2   = 4'd8;
    localparam logic [3:0] ST_ACC   = 4'd9;
    localparam logic [3:0] ST_SCALE = 4'd10;
    localparam logic [3:0] ST_RECIP = 4'd11;
    localparam logic [3:0] ST_OUT   = 4'd12;

    logic [3:0]      state_reg, state_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic            mvalid_reg, mvalid_next;

    always_comb begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        mvalid_next = mvalid_reg & ~m_tready;
        cmd         = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DEC;
                end
            end
            ST_DEC: begin
                if (sts.is_write) begin
                    cmd.mem_wr = 1'b1;
                    state_next = ST_IDLE;
                end else begin
                    cmd.ax_sub = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.ax_mul = 1'b1;
                state_next = ST_CHK;
            end
            ST_CHK: begin
                cmd.ax_chk = 1'b1;
                state_next = ST_BR;
            end
            ST_BR: begin
                cnt_next   = '0;
                state_next = sts.off_grid ? ST_OUT : ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + CNTW'(1);
                if (cnt_reg == CNTW'(DIVN - 1)) begin
                    state_next = ST_RD0;
                end
            end
            ST_RD0: begin
                cmd.rd_en   = 1'b1;
                cmd.rd_sel  = 2'd0;
                cmd.acc_clr = 1'b1;
                state_next  = ST_RD1;
            end
            ST_RD1: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = 2'd1;
                cmd.acc_en = 1'b1;
                state_next = ST_RD2;
            end
            ST_RD2: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = 2'd2;
                cmd.acc_en = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC: begin
                cmd.acc_en = 1'b1;
                state_next = ST_SCALE;
            end
            ST_SCALE: begin
                cmd.scale  = 1'b1;
                state_next = ST_RECIP;
            end
            ST_RECIP: begin
                cmd.recip  = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!mvalid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    mvalid_next  = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            mvalid_reg <= mvalid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = mvalid_reg;

endmodule

`default_nettype wire

// File: tb/heightmap_triangle_height_query_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// heightmap_triangle_height_query_tb: self-checking bench for the height query
// Loads sample grids, runs directed and random query streams under several
// register settings and flow-control mixes, and checks every result transfer
// against an in-bench predictor of the interpolated height.
// ----------------------------------------------------------------------------
module heightmap_triangle_height_query_tb import hmth_pkg::*; ();

    localparam int GS       = 256;
    localparam int LIMIT    = 1000000;
    localparam int DRAIN    = 60;   // longest query latency plus margin

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_addr = '0;
    logic [23:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tuser;

    always #6 aclk = ~aclk;

    heightmap_triangle_height_query u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    typedef struct packed {
        logic [15:0] height;
        logic        on_grid;
    } hres_t;

    // predictor state: grid copy, write-tracking and registers
    logic [7:0]  grid_mdl [GS*GS];
    bit          grid_wr  [GS*GS];
    logic [15:0] scale_r, spacing_r;
    logic [23:0] orgx_r, orgz_r;

    hres_t       height_q[$];
    int          errors = 0;
    int          cycles = 0;
    int          send_idle = 9, recv_idle = 88;

    // axis split: cell index and Q0.16 fraction; 0 when off grid
    function automatic bit axis_split(input logic [23:0] q, input logic [23:0] org,
                                      output int cidx, output longint frac);
        longint d, num, den, idx;
        d = longint'($signed(q)) - longint'($signed(org));
        cidx = 0; frac = 0;
        if (d < 0 || spacing_r == 0) return 0;
        num = d * (GS - 1);
        den = longint'(GS) * spacing_r;
        idx = num / den;
        if (idx >= GS - 1) return 0;
        cidx = int'(idx);
        frac = ((num % den) << 16) / den;
        return 1;
    endfunction

    function automatic longint samp(input int r, input int c);
        return grid_mdl[(r * GS + c) % (GS*GS)];
    endfunction

    function automatic hres_t predict_height(input logic [23:0] qx, input logic [23:0] qz);
        hres_t  r;
        int     gx, gz;
        longint fx, fz, acc, h;
        bit     okx, okz;
        r = '0;
        okx = axis_split(qx, orgx_r, gx, fx);
        okz = axis_split(qz, orgz_r, gz, fz);
        if (!okx || !okz) return r;
        if (fx + fz <= 65536)
            acc = (65536 - fx - fz) * samp(gx, gz) + fx * samp(gx + 1, gz)
                + fz * samp(gx, gz + 1);
        else
            acc = (65536 - fz) * samp(gx + 1, gz) + (fx + fz - 65536) * samp(gx + 1, gz + 1)
                + (65536 - fx) * samp(gx, gz + 1);
        h = (acc * scale_r + 255 * 32768) / (255 * 65536);
        if (h > 65535) h = 65535;
        r.height = h[15:0];
        r.on_grid = 1'b1;
        return r;
    endfunction

    // true if any of the four corners around the query's cell is unwritten
    function automatic bit reads_unwritten(input logic [23:0] qx, input logic [23:0] qz);
        int gx, gz;
        longint fx, fz;
        if (!axis_split(qx, orgx_r, gx, fx) || !axis_split(qz, orgz_r, gz, fz)) return 0;
        return !(grid_wr[gx*GS+gz] && grid_wr[(gx+1)*GS+gz] && grid_wr[gx*GS+gz+1]
                 && grid_wr[(gx+1)*GS+gz+1]);
    endfunction

    // result monitor
    always @(posedge aclk) begin
        hres_t got, exp_r;
        cycles <= cycles + 1;
        if (aresetn && m_tvalid && m_tready) begin
            got.height = m_tdata;
            got.on_grid = m_tuser;
            if (height_q.size() == 0) begin
                $display("%0t unexpected result transfer: expected none actual %h/%b",
                         $time, m_tdata, m_tuser);
                errors <= errors + 1;
            end else begin
                exp_r = height_q.pop_front();
                if (got.height !== exp_r.height || got.on_grid !== exp_r.on_grid) begin
                    $display("%0t height mismatch: expected %h/%b actual %h/%b",
                             $time, exp_r.height, exp_r.on_grid, got.height, got.on_grid);
                    errors <= errors + 1;
                end
            end
        end
    end

    // receiver backpressure, changes on the falling edge
    always @(negedge aclk)
        m_tready <= ($urandom_range(99) >= recv_idle);

    always @(posedge aclk)
        if (cycles > LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end

    task automatic wr_reg(input logic [1:0] idx, input logic [23:0] v);
        @(negedge aclk);
        cfg_wr_en <= 1'b1; cfg_addr <= idx; cfg_wdata <= v;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_HEIGHT_SCALE: scale_r   = v[15:0];
            REG_CELL_SPACING: spacing_r = v[15:0];
            REG_ORIGIN_X:     orgx_r    = v;
            default:          orgz_r    = v;
        endcase
    endtask

    // send one item; expectation logged at the transfer edge
    task automatic send_item(input logic op, input logic [7:0] row, input logic [7:0] col,
                             input logic [7:0] val, input logic [23:0] qx,
                             input logic [23:0] qz);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle) @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {qz, qx, val, col, row};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (op == OP_WRITE) begin
            grid_mdl[row*GS+col] = val;
            grid_wr[row*GS+col] = 1;
        end else begin
            height_q = {height_q, predict_height(qx, qz)};
        end
        @(negedge aclk);
        s_tvalid <= 1'b0;
    endtask

    task automatic wait_idle;
        while (height_q.size() != 0) @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);
    endtask

    // world Q15.8 coordinate of sample index i plus fraction f (0..255)
    function automatic logic [23:0] world_at(input logic [23:0] org, input int i, input int f);
        longint cl256;
        cl256 = longint'(GS) * spacing_r * 256 / (GS - 1);   // cell length * 256
        return 24'(longint'($signed(org)) + (cl256 * i + cl256 * f / 256) / 256);
    endfunction

    typedef struct {
        logic        op;
        logic [7:0]  row, col, val;
        logic [23:0] qx, qz;
        bit          typed;     // fixed expectation given
        hres_t       res;
    } dir_row_t;

    dir_row_t dir_tab[$];

    task automatic rand_phase(input int n);
        int k, r0, c0, i;
        logic [23:0] qx, qz;
        for (k = 0; k < n; k++) begin
            if ($urandom_range(99) < 25) begin
                // write a random sample anywhere
                send_item(OP_WRITE, 8'($urandom), 8'($urandom), 8'($urandom),
                          24'($urandom), 24'($urandom));
            end else begin
                if ($urandom_range(99) < 80) begin
                    // well-formed: on-grid near a random cell
                    r0 = $urandom_range(GS - 2); c0 = $urandom_range(GS - 2);
                    qx = world_at(orgx_r, r0, $urandom_range(255));
                    qz = world_at(orgz_r, c0, $urandom_range(255));
                end else begin
                    qx = 24'($urandom); qz = 24'($urandom);
                end
                if (reads_unwritten(qx, qz)) begin
                    // fill the four corners first
                    for (i = 0; i < 4; i++) begin
                        int gx, gz; longint fx, fz;
                        void'(axis_split(qx, orgx_r, gx, fx));
                        void'(axis_split(qz, orgz_r, gz, fz));
                        send_item(OP_WRITE, 8'(gx + i[0]), 8'(gz + i[1]), 8'($urandom),
                                  24'($urandom), 24'($urandom));
                    end
                end
                send_item(OP_QUERY, 8'($urandom), 8'($urandom), 8'($urandom), qx, qz);
            end
        end
    endtask

    initial begin
        dir_row_t d;
        int i;
        for (i = 0; i < GS*GS; i++) begin grid_mdl[i] = '0; grid_wr[i] = 0; end
        scale_r = HEIGHT_SCALE_RST; spacing_r = CELL_SPACING_RST;
        orgx_r = ORIGIN_RST; orgz_r = ORIGIN_RST;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed table at reset settings
        d = '{default: '0};
        // corner writes at cell (0,0) and the far corner
        d.op = OP_WRITE; d.row = 0; d.col = 0; d.val = 8'd255; dir_tab = {dir_tab, d};
        d.row = 1; d.col = 0; d.val = 8'd0;   dir_tab = {dir_tab, d};
        d.row = 0; d.col = 1; d.val = 8'd128; dir_tab = {dir_tab, d};
        d.row = 1; d.col = 1; d.val = 8'd7;   dir_tab = {dir_tab, d};
        d.row = 254; d.col = 254; d.val = 8'd255; dir_tab = {dir_tab, d};
        d.row = 255; d.col = 254; d.val = 8'd255; dir_tab = {dir_tab, d};
        d.row = 254; d.col = 255; d.val = 8'd255; dir_tab = {dir_tab, d};
        d.row = 255; d.col = 255; d.val = 8'd255; d.qx = 24'hFFFFFF; d.qz = 24'hFFFFFF;
        dir_tab = {dir_tab, d};
        d = '{default: '0}; d.op = OP_QUERY;
        // exact sample point (0,0): full sample gives height_scale
        d.typed = 1; d.res = '{height: HEIGHT_SCALE_RST, on_grid: 1'b1};
        d.row = 8'hFF; d.col = 8'hFF; d.val = 8'hFF; dir_tab = {dir_tab, d};
        // negative offsets are off the grid
        d = '{default: '0}; d.op = OP_QUERY; d.typed = 1; d.res = '0;
        d.qx = 24'h800000; dir_tab = {dir_tab, d};
        d.qx = 24'd0; d.qz = 24'hFFFFFF; dir_tab = {dir_tab, d};
        // far positive extreme is off the grid
        d.qx = 24'h7FFFFF; d.qz = 24'h7FFFFF; dir_tab = {dir_tab, d};
        d = '{default: '0}; d.op = OP_QUERY;
        // interior points on both triangles, one close to the diagonal
        d.qx = 24'd200; d.qz = 24'd300; dir_tab = {dir_tab, d};
        d.qx = 24'd600; d.qz = 24'd650; dir_tab = {dir_tab, d};
        d.qx = 24'd385; d.qz = 24'd385; dir_tab = {dir_tab, d};
        d.qx = 24'd0;   d.qz = 24'd500; dir_tab = {dir_tab, d};
        // last cell, just inside
        d.qx = 24'd196600; d.qz = 24'd196600; dir_tab = {dir_tab, d};
        foreach (dir_tab[j]) begin
            if (dir_tab[j].typed) begin
                if (predict_height(dir_tab[j].qx, dir_tab[j].qz) !== dir_tab[j].res) begin
                    $display("%0t directed row %0d: expected %h actual %h", $time, j,
                             dir_tab[j].res, predict_height(dir_tab[j].qx, dir_tab[j].qz));
                    errors++;
                end
            end
            send_item(dir_tab[j].op, dir_tab[j].row, dir_tab[j].col, dir_tab[j].val,
                      dir_tab[j].qx, dir_tab[j].qz);
        end
        wait_idle();

        // phase 1: defaults, sender lightly idle, receiver heavy stall
        rand_phase(100);
        wait_idle();

        // phase 2: extreme settings, roles swapped
        send_idle = 88; recv_idle = 9;
        wr_reg(REG_HEIGHT_SCALE, 24'hFFFF);
        wr_reg(REG_CELL_SPACING, 24'd1);
        wr_reg(REG_ORIGIN_X, 24'h800000);
        wr_reg(REG_ORIGIN_Z, 24'h7FFF00);
        rand_phase(70);
        wait_idle();

        wr_reg(REG_HEIGHT_SCALE, 24'd0);
        wr_reg(REG_CELL_SPACING, 24'hFFFF);
        wr_reg(REG_ORIGIN_X, 24'hFF0000);
        wr_reg(REG_ORIGIN_Z, 24'h000123);
        rand_phase(50);
        wait_idle();

        // phase 3: no idling, random settings
        send_idle = 0; recv_idle = 0;
        for (i = 0; i < 3; i++) begin
            wr_reg(REG_HEIGHT_SCALE, 24'($urandom));
            wr_reg(REG_CELL_SPACING, 24'($urandom_range(65535, 1)));
            wr_reg(REG_ORIGIN_X, 24'($urandom));
            wr_reg(REG_ORIGIN_Z, 24'($urandom));
            rand_phase(75);
            wait_idle();
        end

        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
